@@ rtl/imhe_pkg.sv @@
// Package for the indexed min-heap engine.
// Holds sizes, operation and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
package imhe_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int KEY_BITS  = 16;
	localparam int POS_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = POS_W + 1;

	// operation codes
	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_BUILD   = 3'd1;
	localparam logic [2:0] OP_EXTRACT = 3'd2;
	localparam logic [2:0] OP_CHANGE  = 3'd3;
	localparam logic [2:0] OP_REMOVE  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_DEAD  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_EX,
		S_POI,
		S_CH,
		S_RM,
		S_RM_DIR,
		S_RM_CMP,
		S_SU_RD,
		S_SU_CMP,
		S_SD_RD,
		S_SD_CMP,
		S_B_NEXT,
		S_B_LD,
		S_B_ROOT,
		S_FIN
	} state_t;

	typedef enum logic [4:0] {
		A_NONE,
		A_LOAD,
		A_BUILD_INIT,
		A_RES_EMPTY,
		A_RES_DEAD,
		A_RES_ZERO,
		A_RD_ROOT_LO,
		A_EX_SWAP,
		A_Q_RD,
		A_CH_SET,
		A_RM_SWAP,
		A_SU_RD,
		A_SU_MOVE,
		A_SD_RD,
		A_SD_MOVE,
		A_PLACE,
		A_B_RD,
		A_LD_MV,
		A_RES_ROOT,
		A_PUBLISH
	} dp_act_t;

	typedef struct packed {
		logic    take;
		dp_act_t act;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       item_big;
		logic       dead;
		logic       ch_lt;
		logic       ch_gt;
		logic       q_is_lo;
		logic       has_parent;
		logic       su_moves;
		logic       has_child;
		logic       sd_moves;
		logic       i_done;
		logic       out_busy;
	} stat_t;

endpackage

@@ rtl/indexed_min_heap_engine_unit.sv @@
// Indexed binary min-heap engine: load keys, build, extract the minimum,
// change an item's key or remove an item, one operation at a time. Each
// operation is accepted in the idle state and delivers one result through
// an output register, so the next operation can be taken while a result
// waits. Extract, change key and remove walk the heap one level at a
// time, and build sifts down each position in turn and then reports
// the root. Each level is a registered read of the key and item stores
// and a compare-and-write on their single write port.
// The stores have no clearing pass after reset; entries are defined once
// loaded.
module indexed_min_heap_engine_unit
	import imhe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic [POS_W-1:0]    item,
	input  logic [KEY_BITS-1:0] new_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [POS_W-1:0]    out_item,
	output logic [KEY_BITS-1:0] out_key,
	output logic [POS_W-1:0]    out_position,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	cmd_t  cmd;
	stat_t st;

	// sequence operations
	imhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd)
	);

	// stores and registers
	imhe_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_valid     (in_valid),
		.opcode       (opcode),
		.item         (item),
		.new_key      (new_key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_item     (out_item),
		.out_key      (out_key),
		.out_position (out_position),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	assign in_ready = cmd.take;

endmodule

@@ rtl/imhe_ctrl.sv @@
// Controller state machine of the indexed min-heap engine.
// Sequences each operation as datapath actions; uses imhe_pkg.
module imhe_ctrl
	import imhe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				unique case (st.op) inside
					OP_LOAD:    state_d = S_FIN;
					OP_BUILD:   state_d = S_B_NEXT;
					OP_EXTRACT: state_d = st.empty ? S_FIN : S_EX;
					OP_CHANGE, OP_REMOVE: begin
						state_d = (st.empty || st.item_big) ? S_FIN : S_POI;
					end
					default:    state_d = S_FIN;
				endcase
			end
			S_EX:     state_d = S_SD_RD;
			S_POI: begin
				if (st.dead) state_d = S_FIN;
				else if (st.op == OP_CHANGE) state_d = S_CH;
				else state_d = S_RM;
			end
			S_CH: begin
				if (st.ch_lt) state_d = S_SU_RD;
				else if (st.ch_gt) state_d = S_SD_RD;
				else state_d = S_FIN;
			end
			S_RM:     state_d = st.q_is_lo ? S_FIN : S_RM_DIR;
			S_RM_DIR: state_d = st.has_parent ? S_RM_CMP : S_SD_RD;
			S_RM_CMP: state_d = st.su_moves ? S_SU_RD : S_SD_RD;
			S_SU_RD:  state_d = st.has_parent ? S_SU_CMP : S_FIN;
			S_SU_CMP: state_d = st.su_moves ? S_SU_RD : S_FIN;
			S_SD_RD: begin
				if (st.has_child) state_d = S_SD_CMP;
				else state_d = (st.op == OP_BUILD) ? S_B_NEXT : S_FIN;
			end
			S_SD_CMP: begin
				if (st.sd_moves) state_d = S_SD_RD;
				else state_d = (st.op == OP_BUILD) ? S_B_NEXT : S_FIN;
			end
			S_B_NEXT: state_d = st.i_done ? S_B_ROOT : S_B_LD;
			S_B_LD:   state_d = S_SD_RD;
			S_B_ROOT: state_d = S_FIN;
			S_FIN: begin
				if (!st.out_busy) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.take = (state_q == S_IDLE);
		cmd.act  = A_NONE;
		unique case (state_q)
			S_IDLE: cmd.act = A_NONE;
			S_DISP: begin
				unique case (st.op) inside
					OP_LOAD:    cmd.act = A_LOAD;
					OP_BUILD:   cmd.act = A_BUILD_INIT;
					OP_EXTRACT: cmd.act = st.empty ? A_RES_EMPTY : A_RD_ROOT_LO;
					OP_CHANGE, OP_REMOVE: begin
						if (st.empty) cmd.act = A_RES_EMPTY;
						else if (st.item_big) cmd.act = A_RES_DEAD;
						else cmd.act = A_NONE;
					end
					default:    cmd.act = A_RES_ZERO;
				endcase
			end
			S_EX:     cmd.act = A_EX_SWAP;
			S_POI:    cmd.act = st.dead ? A_RES_DEAD : A_Q_RD;
			S_CH:     cmd.act = A_CH_SET;
			S_RM:     cmd.act = A_RM_SWAP;
			S_RM_DIR: cmd.act = st.has_parent ? A_SU_RD : A_NONE;
			S_RM_CMP: cmd.act = st.su_moves ? A_SU_MOVE : A_NONE;
			S_SU_RD:  cmd.act = st.has_parent ? A_SU_RD : A_PLACE;
			S_SU_CMP: cmd.act = st.su_moves ? A_SU_MOVE : A_PLACE;
			S_SD_RD:  cmd.act = st.has_child ? A_SD_RD : A_PLACE;
			S_SD_CMP: cmd.act = st.sd_moves ? A_SD_MOVE : A_PLACE;
			S_B_NEXT: cmd.act = st.i_done ? A_RD_ROOT_LO : A_B_RD;
			S_B_LD:   cmd.act = A_LD_MV;
			S_B_ROOT: cmd.act = A_RES_ROOT;
			S_FIN:    cmd.act = st.out_busy ? A_NONE : A_PUBLISH;
			default:  cmd.act = A_NONE;
		endcase
	end

endmodule

@@ rtl/imhe_dpath.sv @@
// Datapath of the indexed min-heap engine: the three stores, the cursor,
// the moving element, the item count register and the result registers.
// Uses imhe_pkg; driven by imhe_ctrl through cmd_t and stat_t.
module imhe_dpath
	import imhe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic                in_valid,
	input  logic [2:0]          opcode,
	input  logic [POS_W-1:0]    item,
	input  logic [KEY_BITS-1:0] new_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [POS_W-1:0]    out_item,
	output logic [KEY_BITS-1:0] out_key,
	output logic [POS_W-1:0]    out_position,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	// stores
	logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
	logic [POS_W-1:0]    iap_mem [MAX_ITEMS];
	logic [POS_W-1:0]    poi_mem [MAX_ITEMS];

	logic [KEY_BITS-1:0] key_a_q, key_b_q;
	logic [POS_W-1:0]    iap_a_q, iap_b_q, poi_rd_q;

	logic [CNT_W-1:0]    item_count_q, lo_q, i_q;
	logic [2:0]          op_q;
	logic [POS_W-1:0]    item_q, q_q, mv_item_q;
	logic [KEY_BITS-1:0] nk_q, mv_key_q;
	logic [1:0]          res_st_q;
	logic [POS_W-1:0]    res_item_q, res_pos_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic                out_valid_q;
	logic [1:0]          out_st_q;
	logic [POS_W-1:0]    out_item_q, out_pos_q;
	logic [KEY_BITS-1:0] out_key_q;

	logic [CNT_W-1:0]    n, nm1, hidx, pk, p_full;
	logic [POS_W-1:0]    parent_pos, c, cm1, sel_pos, sel_item;
	logic [CNT_W:0]      k2, child_sum, c_full;
	logic [KEY_BITS-1:0] sel_key;
	logic                pick_c;
	logic [POS_W-1:0]    rd_a, rd_b;
	logic                wr_en;
	logic [POS_W-1:0]    wr_pos, wr_item;
	logic [KEY_BITS-1:0] wr_key;

	// clamp the item count to 1..MAX_ITEMS
	always_comb begin
		if (item_count_q == '0) n = CNT_W'(1);
		else if (item_count_q > CNT_W'(MAX_ITEMS)) n = CNT_W'(MAX_ITEMS);
		else n = item_count_q;
	end

	// heap index arithmetic on the cursor
	always_comb begin
		nm1        = n - CNT_W'(1);
		hidx       = nm1 - {1'b0, q_q};
		pk         = (hidx - CNT_W'(1)) >> 1;
		p_full     = nm1 - pk;
		parent_pos = p_full[POS_W-1:0];
		k2         = {hidx, 1'b1};
		child_sum  = k2 + {1'b0, lo_q};
		c_full     = {1'b0, nm1} - k2;
		c          = c_full[POS_W-1:0];
		cm1        = c - POS_W'(1);
		pick_c     = ({1'b0, c} == lo_q) || (key_a_q <= key_b_q);
		sel_pos    = pick_c ? c : cm1;
		sel_key    = pick_c ? key_a_q : key_b_q;
		sel_item   = pick_c ? iap_a_q : iap_b_q;
	end

	// status to the controller
	always_comb begin
		st.op         = op_q;
		st.empty      = (lo_q >= n);
		st.item_big   = ({1'b0, item_q} >= n);
		st.dead       = ({1'b0, poi_rd_q} < lo_q) || ({1'b0, poi_rd_q} >= n);
		st.ch_lt      = (nk_q < key_a_q);
		st.ch_gt      = (nk_q > key_a_q);
		st.q_is_lo    = ({1'b0, q_q} == lo_q);
		st.has_parent = ({1'b0, q_q} < nm1);
		st.su_moves   = (key_a_q > mv_key_q);
		st.has_child  = (child_sum <= {1'b0, nm1});
		st.sd_moves   = (sel_key < mv_key_q);
		st.i_done     = (i_q >= n);
		st.out_busy   = out_valid_q && !out_ready;
	end

	// select read addresses
	always_comb begin
		rd_a = q_q;
		rd_b = lo_q[POS_W-1:0];
		case (cmd.act)
			A_RD_ROOT_LO: rd_a = nm1[POS_W-1:0];
			A_Q_RD:       rd_a = poi_rd_q;
			A_B_RD:       rd_a = i_q[POS_W-1:0];
			A_SD_RD: begin
				rd_a = c;
				rd_b = cm1;
			end
			A_SU_RD:      rd_a = parent_pos;
			default:      rd_a = q_q;
		endcase
	end

	// select the placement written this cycle
	always_comb begin
		wr_en   = 1'b1;
		wr_pos  = q_q;
		wr_item = mv_item_q;
		wr_key  = mv_key_q;
		case (cmd.act) inside
			A_LOAD: begin
				wr_en   = ~st.item_big;
				wr_pos  = item_q;
				wr_item = item_q;
				wr_key  = nk_q;
			end
			A_EX_SWAP, A_RM_SWAP: begin
				wr_pos  = lo_q[POS_W-1:0];
				wr_item = iap_a_q;
				wr_key  = key_a_q;
			end
			A_SD_MOVE: begin
				wr_item = sel_item;
				wr_key  = sel_key;
			end
			A_SU_MOVE: begin
				wr_item = iap_a_q;
				wr_key  = key_a_q;
			end
			A_PLACE:   wr_en = 1'b1;
			default:   wr_en = 1'b0;
		endcase
	end

	// key and item stores: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_pos] <= wr_key;
			iap_mem[wr_pos] <= wr_item;
		end
		key_a_q <= key_mem[rd_a];
		key_b_q <= key_mem[rd_b];
		iap_a_q <= iap_mem[rd_a];
		iap_b_q <= iap_mem[rd_b];
	end

	// position store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) poi_mem[wr_item] <= wr_pos;
		poi_rd_q <= poi_mem[item_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= CNT_W'(MAX_ITEMS);
			lo_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) item_count_q <= cfg_wdata;
			case (cmd.act) inside
				A_BUILD_INIT:         lo_q <= '0;
				A_EX_SWAP, A_RM_SWAP: lo_q <= lo_q + CNT_W'(1);
				default:              lo_q <= lo_q;
			endcase
			if (cmd.act == A_PUBLISH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take && in_valid) begin
			op_q   <= opcode;
			item_q <= item;
			nk_q   <= new_key;
		end
		case (cmd.act) inside
			A_LOAD: begin
				res_st_q   <= ST_OK;
				res_item_q <= item_q;
				res_key_q  <= st.item_big ? '0 : nk_q;
				res_pos_q  <= st.item_big ? '0 : item_q;
			end
			A_BUILD_INIT: i_q <= CNT_W'(1);
			A_RES_EMPTY: begin
				res_st_q   <= ST_EMPTY;
				res_item_q <= '0;
				res_key_q  <= '0;
				res_pos_q  <= '0;
			end
			A_RES_DEAD: begin
				res_st_q   <= ST_DEAD;
				res_item_q <= item_q;
				res_key_q  <= '0;
				res_pos_q  <= '0;
			end
			A_RES_ZERO: begin
				res_st_q   <= ST_OK;
				res_item_q <= '0;
				res_key_q  <= '0;
				res_pos_q  <= '0;
			end
			A_EX_SWAP, A_RM_SWAP: begin
				res_st_q   <= ST_OK;
				res_item_q <= iap_a_q;
				res_key_q  <= key_a_q;
				res_pos_q  <= lo_q[POS_W-1:0];
				mv_item_q  <= iap_b_q;
				mv_key_q   <= key_b_q;
				if (cmd.act == A_EX_SWAP) q_q <= nm1[POS_W-1:0];
			end
			A_Q_RD:    q_q <= poi_rd_q;
			A_CH_SET: begin
				res_st_q   <= ST_OK;
				res_item_q <= item_q;
				res_key_q  <= nk_q;
				res_pos_q  <= q_q;
				mv_item_q  <= iap_a_q;
				mv_key_q   <= nk_q;
			end
			A_SU_MOVE: q_q <= parent_pos;
			A_SD_MOVE: q_q <= sel_pos;
			A_PLACE: begin
				if (op_q == OP_CHANGE) res_pos_q <= q_q;
			end
			A_B_RD: begin
				q_q <= i_q[POS_W-1:0];
				i_q <= i_q + CNT_W'(1);
			end
			A_LD_MV: begin
				mv_item_q <= iap_a_q;
				mv_key_q  <= key_a_q;
			end
			A_RES_ROOT: begin
				res_st_q   <= ST_OK;
				res_item_q <= iap_a_q;
				res_key_q  <= key_a_q;
				res_pos_q  <= nm1[POS_W-1:0];
			end
			A_PUBLISH: begin
				out_st_q   <= res_st_q;
				out_item_q <= res_item_q;
				out_key_q  <= res_key_q;
				out_pos_q  <= res_pos_q;
			end
			default: i_q <= i_q;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign out_item     = out_item_q;
	assign out_key      = out_key_q;
	assign out_position = out_pos_q;

endmodule

@@ rtl/imhe_checker.sv @@
// Port-level checker for the indexed min-heap engine, bound to the top.
// Uses imhe_pkg for sizes and status codes.
module imhe_checker
	import imhe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          status,
	input logic [POS_W-1:0]    out_item,
	input logic [KEY_BITS-1:0] out_key,
	input logic [POS_W-1:0]    out_position
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one operation at a time: no transfer right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// status stays within its codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_DEAD))
		else $error("bad status code");

	// empty heap reports all-zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |->
			out_item == '0 && out_key == '0 && out_position == '0)
		else $error("empty result not zero");

	// dead item reports zero key and position
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DEAD |-> out_key == '0 && out_position == '0)
		else $error("dead item result not zero");

endmodule

bind indexed_min_heap_engine_unit imhe_checker u_chk (.*);
